FILE: rtl/fxt_text_table_decoder_core_defines.svh
// assertion macros used by the decoder rtl (the parser in fxt_ttd_back)
`ifndef FXT_TEXT_TABLE_DECODER_CORE_DEFINES_SVH
`define FXT_TEXT_TABLE_DECODER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FXT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FXT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fxt_ttd_pkg.sv
package fxt_ttd_pkg;

  // number of leading bytes that get the running key subtracted
  localparam logic [3:0] CIPHER_PREFIX_LEN = 4'd8;

  // variant selection bytes and their starting keys
  localparam logic [7:0] VARIANT_LOW_BYTE  = 8'hBF;
  localparam logic [7:0] VARIANT_HIGH_BYTE = 8'hA6;
  localparam logic [7:0] KEY_LOW_START     = 8'h63;
  localparam logic [7:0] KEY_HIGH_START    = 8'h67;

  // character offsets, the low one is minus one modulo 256
  localparam logic [7:0] OFFSET_HIGH = 8'd28;
  localparam logic [7:0] OFFSET_LOW  = 8'hFF;

  // escape detection sum and escaped byte bias
  localparam logic [8:0] ESC_CODE  = 9'd195;
  localparam logic [7:0] ESC_BIAS  = 8'd64;

  // framing characters
  localparam logic [7:0] CHAR_OPEN  = 8'h5B;
  localparam logic [7:0] CHAR_CLOSE = 8'h5D;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // result tags
  typedef enum logic [2:0] {
    TAG_KEY_CHAR   = 3'd0,
    TAG_KEY_END    = 3'd1,
    TAG_VALUE_CHAR = 3'd2,
    TAG_ENTRY_END  = 3'd3,
    TAG_STOPPED    = 3'd4
  } ttd_tag_t;

  // work item from the front decoder to the parser
  typedef struct packed {
    logic       is_stop;
    logic [7:0] ch;
  } ttd_op_t;

endpackage

FILE: rtl/fxt_text_table_decoder_core.sv
// a result passes the two-entry queue and then the output register before out_valid rises
// throughput: one raw byte per cycle while in_stall is low; queue and output register absorb stalls
// in_stall rises only when the queue is full, i.e. after the output side has stalled
// reset: synchronous active-low rst_n clears key, counters, escape and parse state;
// the next byte after reset is treated as the variant selection byte
module fxt_text_table_decoder_core
  import fxt_ttd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_raw_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_tag,
  output logic [7:0] out_text_char
);

  logic    q_full;
  logic    q_empty;
  logic    q_push;
  logic    q_pop;
  ttd_op_t q_push_op;
  ttd_op_t q_head;

  assign in_stall = q_full;

  // byte decryption and escape handling
  fxt_ttd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_raw_byte (in_raw_byte),
    .q_full      (q_full),
    .push        (q_push),
    .push_op     (q_push_op)
  );

  // decoupling queue
  fxt_ttd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_push_op),
    .pop     (q_pop),
    .full    (q_full),
    .empty   (q_empty),
    .head    (q_head)
  );

  // entry framing parser
  fxt_ttd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tag       (out_tag),
    .out_text_char (out_text_char)
  );

endmodule

FILE: rtl/fxt_ttd_front.sv
module fxt_ttd_front
  import fxt_ttd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_raw_byte,
  input  logic       q_full,
  output logic       push,
  output ttd_op_t    push_op
);

  logic [3:0] bytes_seen_r, bytes_seen_nxt;
  logic [7:0] cipher_key_r, cipher_key_nxt;
  logic       high_offset_r, high_offset_nxt;
  logic       escape_r, escape_nxt;
  logic       stopped_r, stopped_nxt;

  logic       accept;
  logic       first;
  logic       first_ok;
  logic       hi_eff;
  logic [7:0] key_eff;
  logic [7:0] off8;
  logic [7:0] dec_c;
  logic       esc_hit;
  logic [3:0] seen_inc;

  assign accept = in_valid && !q_full;
  assign first  = (bytes_seen_r == 4'd0);
  assign first_ok = (in_raw_byte == VARIANT_LOW_BYTE) || (in_raw_byte == VARIANT_HIGH_BYTE);
  assign seen_inc = (bytes_seen_r == 4'hF) ? bytes_seen_r : bytes_seen_r + 4'd1;

  // variant in force for this byte
  assign hi_eff  = first ? (in_raw_byte == VARIANT_HIGH_BYTE) : high_offset_r;
  assign key_eff = first ? (hi_eff ? KEY_HIGH_START : KEY_LOW_START) : cipher_key_r;
  assign off8    = hi_eff ? OFFSET_HIGH : OFFSET_LOW;

  // key subtraction over the prefix
  assign dec_c = (bytes_seen_r < CIPHER_PREFIX_LEN) ? in_raw_byte - key_eff : in_raw_byte;

  // escape when decoded byte plus offset hits the escape code
  assign esc_hit = hi_eff ? (({1'b0, dec_c} + {1'b0, OFFSET_HIGH}) == ESC_CODE)
                          : ({1'b0, dec_c} == ESC_CODE + 9'd1);

  // classify the accepted byte
  always_comb begin
    bytes_seen_nxt  = bytes_seen_r;
    cipher_key_nxt  = cipher_key_r;
    high_offset_nxt = high_offset_r;
    escape_nxt      = escape_r;
    stopped_nxt     = stopped_r;
    push            = 1'b0;
    push_op         = '0;
    if (accept && !stopped_r) begin
      if (escape_r) begin
        escape_nxt     = 1'b0;
        bytes_seen_nxt = seen_inc;
        push           = 1'b1;
        push_op.ch     = in_raw_byte + ESC_BIAS + (high_offset_r ? OFFSET_HIGH : OFFSET_LOW);
      end else if (first && !first_ok) begin
        stopped_nxt     = 1'b1;
        push            = 1'b1;
        push_op.is_stop = 1'b1;
      end else begin
        high_offset_nxt = hi_eff;
        cipher_key_nxt  = (bytes_seen_r < CIPHER_PREFIX_LEN) ? {key_eff[6:0], 1'b0} : key_eff;
        bytes_seen_nxt  = seen_inc;
        if (esc_hit) begin
          escape_nxt = 1'b1;
        end else begin
          push       = 1'b1;
          push_op.ch = dec_c + off8;
        end
      end
    end
  end

  // front state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r  <= 4'd0;
      cipher_key_r  <= 8'd0;
      high_offset_r <= 1'b0;
      escape_r      <= 1'b0;
      stopped_r     <= 1'b0;
    end else begin
      bytes_seen_r  <= bytes_seen_nxt;
      cipher_key_r  <= cipher_key_nxt;
      high_offset_r <= high_offset_nxt;
      escape_r      <= escape_nxt;
      stopped_r     <= stopped_nxt;
    end
  end

endmodule

FILE: rtl/fxt_ttd_queue.sv
module fxt_ttd_queue
  import fxt_ttd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  ttd_op_t push_op,
  input  logic    pop,
  output logic    full,
  output logic    empty,
  output ttd_op_t head
);

  ttd_op_t    mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

  // pointer and fill updates
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

FILE: rtl/fxt_ttd_back.sv
`include "fxt_text_table_decoder_core_defines.svh"

module fxt_ttd_back
  import fxt_ttd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  ttd_op_t    q_head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_tag,
  output logic [7:0] out_text_char
);

  typedef enum logic [1:0] {
    PH_OPEN  = 2'd0,
    PH_KEY   = 2'd1,
    PH_VALUE = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic       key_nonempty_r, key_nonempty_nxt;
  logic       out_valid_r, out_valid_nxt;
  ttd_tag_t   out_tag_r, out_tag_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       emit;

  assign pop = !q_empty && (!out_valid_r || !out_stall);

  // parse one decoded character
  always_comb begin
    phase_nxt        = phase_r;
    key_nonempty_nxt = key_nonempty_r;
    emit             = 1'b0;
    out_tag_nxt      = out_tag_r;
    out_char_nxt     = out_char_r;
    if (pop && phase_r != PH_STOP) begin
      if (q_head.is_stop) begin
        phase_nxt    = PH_STOP;
        emit         = 1'b1;
        out_tag_nxt  = TAG_STOPPED;
        out_char_nxt = CHAR_NUL;
      end else begin
        case (phase_r)
          PH_OPEN: begin
            if (q_head.ch != CHAR_OPEN) begin
              phase_nxt    = PH_STOP;
              emit         = 1'b1;
              out_tag_nxt  = TAG_STOPPED;
              out_char_nxt = CHAR_NUL;
            end else begin
              phase_nxt        = PH_KEY;
              key_nonempty_nxt = 1'b0;
            end
          end
          PH_KEY: begin
            emit = 1'b1;
            if (q_head.ch == CHAR_CLOSE) begin
              out_char_nxt = CHAR_NUL;
              if (!key_nonempty_r) begin
                phase_nxt   = PH_STOP;
                out_tag_nxt = TAG_STOPPED;
              end else begin
                phase_nxt   = PH_VALUE;
                out_tag_nxt = TAG_KEY_END;
              end
            end else begin
              key_nonempty_nxt = 1'b1;
              out_tag_nxt      = TAG_KEY_CHAR;
              out_char_nxt     = q_head.ch;
            end
          end
          PH_VALUE: begin
            emit = 1'b1;
            if (q_head.ch == CHAR_NUL) begin
              phase_nxt    = PH_OPEN;
              out_tag_nxt  = TAG_ENTRY_END;
              out_char_nxt = CHAR_NUL;
            end else begin
              out_tag_nxt  = TAG_VALUE_CHAR;
              out_char_nxt = q_head.ch;
            end
          end
          default: begin
            emit = 1'b0;
          end
        endcase
      end
    end
    // output register: load on emit, clear once taken
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // parser state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_OPEN;
      key_nonempty_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      key_nonempty_r <= key_nonempty_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    out_tag_r  <= out_tag_nxt;
    out_char_r <= out_char_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_tag       = out_tag_r;
  assign out_text_char = out_char_r;

  // checks
  `FXT_ASSERT_NEXT(a_quiet_after_stop, clk, rst_n,
    (phase_r == PH_STOP && !(out_valid_r && out_stall)), !out_valid_r,
    "result after stop")
  `FXT_ASSERT_NOW(a_stop_tag_phase, clk, rst_n,
    (out_valid_r && out_tag_r == TAG_STOPPED), (phase_r == PH_STOP),
    "stopped tag without stop phase")
  `FXT_ASSERT_NOW(a_mark_char_zero, clk, rst_n,
    (out_valid_r && (out_tag_r == TAG_KEY_END || out_tag_r == TAG_ENTRY_END ||
     out_tag_r == TAG_STOPPED)), (out_char_r == CHAR_NUL),
    "end mark carries a character")
  `FXT_ASSERT_NEXT(a_empty_key_stops, clk, rst_n,
    (pop && phase_r == PH_KEY && !q_head.is_stop && q_head.ch == CHAR_CLOSE &&
     !key_nonempty_r), (phase_r == PH_STOP && out_valid_r),
    "empty key did not stop")

endmodule
